/* sv/button_press_classifier_core_macros.svh */
// Assertion macros for the button press classifier.
// Used by button_press_classifier_core; expects clk and rst_n in scope.
`ifndef BUTTON_PRESS_CLASSIFIER_CORE_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_CORE_MACROS_SVH

// Condition that must hold at every clock edge out of reset
`define BPC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define BPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/bpc_pkg.sv */
// Shared types and constants for the button press classifier.
// No dependencies; imported by bpc_step and button_press_classifier_core.
`timescale 1ns / 1ps

package bpc_pkg;

    localparam int CHECK_W    = 8;
    localparam int DELAY_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_TDATA_W = 8;
    localparam int OUT_TDATA_W = 8;

    localparam logic [CHECK_W-1:0] CHECK_MAX = {CHECK_W{1'b1}};
    localparam logic [DELAY_W-1:0] DELAY_MAX = {DELAY_W{1'b1}};

    // Reset values of the configuration registers
    localparam logic [CHECK_W-1:0] PRESS_CHECKS_RST   = 8'd5;
    localparam logic [CHECK_W-1:0] RELEASE_CHECKS_RST = 8'd5;
    localparam logic [DELAY_W-1:0] SHORT_DELAY_RST    = 16'd50;
    localparam logic [DELAY_W-1:0] LONG_DELAY_RST     = 16'd300;
    localparam logic [DELAY_W-1:0] HOLD_DELAY_RST     = 16'd1000;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRESS_CHECKS   = 3'd0,
        REG_RELEASE_CHECKS = 3'd1,
        REG_SHORT_DELAY    = 3'd2,
        REG_LONG_DELAY     = 3'd3,
        REG_HOLD_DELAY     = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [CHECK_W-1:0] press_checks;
        logic [CHECK_W-1:0] release_checks;
        logic [DELAY_W-1:0] short_delay;
        logic [DELAY_W-1:0] long_delay;
        logic [DELAY_W-1:0] hold_delay;
    } bpc_cfg_t;

    typedef struct packed {
        logic               pressed_mode;
        logic [CHECK_W-1:0] sample_count;
        logic [DELAY_W-1:0] held_ticks;
        logic               short_mark;
        logic               long_mark;
        logic               hold_mark;
    } bpc_state_t;

    // Field order matches the output tdata, lowest bit last here
    typedef struct packed {
        logic hold_active;
        logic hold_release_event;
        logic long_press_event;
        logic short_press_event;
        logic fast_press_event;
    } bpc_result_t;

    localparam int RESULT_W = $bits(bpc_result_t);

endpackage

/* sv/bpc_step.sv */
// Per-item update of the debounce and press-length classifier.
// Pure combinational; uses types from bpc_pkg.
`timescale 1ns / 1ps

module bpc_step
    import bpc_pkg::*;
(
    input  bpc_cfg_t    cfg,
    input  bpc_state_t  state_cur,
    input  logic        button_level,
    output bpc_state_t  state_next,
    output bpc_result_t result
);

    logic [CHECK_W-1:0] count_inc;
    logic [DELAY_W-1:0] held_inc;

    // Saturating counters
    assign count_inc = (state_cur.sample_count == CHECK_MAX) ?
                       CHECK_MAX : state_cur.sample_count + 1'b1;
    assign held_inc  = (state_cur.held_ticks == DELAY_MAX) ?
                       DELAY_MAX : state_cur.held_ticks + 1'b1;

    always_comb
    begin
        state_next = state_cur;
        result     = '0;

        if (!state_cur.pressed_mode)
        begin
            // Waiting for a press: count consecutive low samples
            if (button_level)
            begin
                state_next.sample_count = '0;
            end
            else if (count_inc >= cfg.press_checks)
            begin
                result.fast_press_event = 1'b1;
                state_next.sample_count = '0;
                state_next.held_ticks   = '0;
                state_next.pressed_mode = 1'b1;
            end
            else
            begin
                state_next.sample_count = count_inc;
            end
        end
        else if (!button_level)
        begin
            // Held: advance duration, compares applied in fixed order
            state_next.sample_count = '0;
            state_next.held_ticks   = held_inc;
            if (held_inc > cfg.short_delay)
            begin
                state_next.short_mark = 1'b1;
            end
            if (held_inc > cfg.long_delay)
            begin
                state_next.short_mark = 1'b0;
                state_next.long_mark  = 1'b1;
            end
            if (held_inc > cfg.hold_delay)
            begin
                state_next.long_mark = 1'b0;
                state_next.hold_mark = 1'b1;
            end
        end
        else if (count_inc >= cfg.release_checks)
        begin
            // Release confirmed: report the marks, then clear everything
            result.short_press_event  = state_cur.short_mark;
            result.long_press_event   = state_cur.long_mark;
            result.hold_release_event = state_cur.hold_mark;
            state_next = '0;
        end
        else
        begin
            state_next.sample_count = count_inc;
        end

        result.hold_active = state_next.hold_mark;
    end

endmodule

/* sv/button_press_classifier_core.sv */
// Top level of the button press classifier: config registers, state, output skid.
// Depends on bpc_pkg, bpc_step and button_press_classifier_core_macros.svh.
`timescale 1ns / 1ps
`include "button_press_classifier_core_macros.svh"

// Usage:
//   s_axis carries one sampled button level per item (tdata bit 0, 0 = pressed).
//   m_axis returns exactly one result item for each input item, in order.
//   cfg writes one register per handshake (index 0..4: press_checks,
//   release_checks, short_delay, long_delay, hold_delay); other indexes are
//   ignored. cfg_ready is always high. Write only while the block is idle.
// Timing:
//   The result of an accepted item is loaded into the result register, or into
//   the skid register while m_axis holds a waiting result. Throughput is one item
//   per cycle while s_axis_tready is high.
// Stall:
//   A two-entry output stage (result register plus skid register) lets one
//   more item in while a result waits; s_axis_tready drops only once the
//   skid register is full, and returns as soon as m_axis takes a result.
// Reset:
//   rst_n clears the classifier state, empties the output stage and loads the
//   register defaults (5, 5, 50, 300, 1000).

module button_press_classifier_core
    import bpc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [0] button_level, [7:1] zero
    // Result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [0] fast_press_event,
                                                   // [1] short_press_event,
                                                   // [2] long_press_event,
                                                   // [3] hold_release_event,
                                                   // [4] hold_active, [7:5] zero
    // Configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    bpc_cfg_t    cfg_reg;
    bpc_state_t  state_reg;
    bpc_state_t  state_next;
    bpc_result_t step_result;
    bpc_result_t out_reg;
    bpc_result_t skid_reg;
    logic        out_valid_reg;
    logic        skid_valid_reg;
    logic        s_fire;
    logic        out_free;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !skid_valid_reg;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.press_checks   <= PRESS_CHECKS_RST;
            cfg_reg.release_checks <= RELEASE_CHECKS_RST;
            cfg_reg.short_delay    <= SHORT_DELAY_RST;
            cfg_reg.long_delay     <= LONG_DELAY_RST;
            cfg_reg.hold_delay     <= HOLD_DELAY_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PRESS_CHECKS:   cfg_reg.press_checks   <= cfg_data[CHECK_W-1:0];
                REG_RELEASE_CHECKS: cfg_reg.release_checks <= cfg_data[CHECK_W-1:0];
                REG_SHORT_DELAY:    cfg_reg.short_delay    <= cfg_data[DELAY_W-1:0];
                REG_LONG_DELAY:     cfg_reg.long_delay     <= cfg_data[DELAY_W-1:0];
                REG_HOLD_DELAY:     cfg_reg.hold_delay     <= cfg_data[DELAY_W-1:0];
                default:            ;
            endcase
        end
    end

    // Per-item classifier update
    bpc_step u_step (
        .cfg          (cfg_reg),
        .state_cur    (state_reg),
        .button_level (s_axis_tdata[0]),
        .state_next   (state_next),
        .result       (step_result)
    );

    // Classifier state advances once per accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (s_fire)
        begin
            state_reg <= state_next;
        end
    end

    // Output stage: result register backed by a skid register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= s_fire;
            end
        end
        else if (s_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (s_fire)
            begin
                out_reg <= step_result;
            end
        end
        else if (s_fire)
        begin
            skid_reg <= step_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-RESULT_W){1'b0}}, out_reg};

    // Checks on the output stage and the classifier state
    `BPC_ASSERT_ALWAYS(a_skid_needs_out, !skid_valid_reg || out_valid_reg,
        "skid register full while result register empty")
    `BPC_ASSERT_ALWAYS(a_held_only_pressed, state_reg.pressed_mode || state_reg.held_ticks == '0,
        "hold duration nonzero while waiting for a press")
    `BPC_ASSERT_NEXT(a_fast_enters_pressed, s_fire && step_result.fast_press_event,
        state_reg.pressed_mode, "confirmed press did not enter pressed mode")
    `BPC_ASSERT_NEXT(a_release_clears,
        s_fire && state_reg.pressed_mode && !state_next.pressed_mode,
        !state_reg.short_mark && !state_reg.long_mark && !state_reg.hold_mark,
        "marks not cleared after confirmed release")

endmodule
